/* hdl/sgps_pkg.sv */
// sgps_pkg: shared types and constants for the path smoother
// holds coordinate, tap, pipeline slot and result types plus tap reset values
// no dependencies
package sgps_pkg;

    localparam int COORD_W             = 32;
    localparam int TAP_W               = 18;
    localparam int PROD_W              = COORD_W + TAP_W;
    localparam int FRAC_W              = 16;
    localparam int NUM_TAPS            = 5;
    localparam int REG_IDX_W           = 3;
    localparam int HALF_WINDOW_DEFAULT = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TAP_W-1:0]   tap_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    localparam tap_t TAP_CENTER_RST = 18'sd16738;
    localparam tap_t TAP_OFF1_RST   = 18'sd15319;
    localparam tap_t TAP_OFF2_RST   = 18'sd11064;
    localparam tap_t TAP_OFF3_RST   = 18'sd3972;
    localparam tap_t TAP_OFF4_RST   = -18'sd5958;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TAP_CENTER = 3'd0,
        REG_TAP_OFF1   = 3'd1,
        REG_TAP_OFF2   = 3'd2,
        REG_TAP_OFF3   = 3'd3,
        REG_TAP_OFF4   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic   valid;
        logic   smooth;
        logic   last;
        coord_t raw_x;
        coord_t raw_y;
    } slot_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   smoothed;
        logic   sat;
        logic   last;
    } result_t;

endpackage

/* hdl/sgps_cell.sv */
// sgps_cell: one tap cell of the delay line
// holds one raw point, passes it to the next cell and registers tap times point
// depends on sgps_pkg
module sgps_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  logic            advance,
    input  sgps_pkg::coord_t in_x,
    input  sgps_pkg::coord_t in_y,
    input  sgps_pkg::tap_t  tap,
    output sgps_pkg::coord_t out_x,
    output sgps_pkg::coord_t out_y,
    output sgps_pkg::prod_t prod_x,
    output sgps_pkg::prod_t prod_y
);
    import sgps_pkg::*;

    coord_t x_reg;
    coord_t y_reg;
    prod_t  prod_x_reg;
    prod_t  prod_y_reg;
    prod_t  prod_x_next;
    prod_t  prod_y_next;

    always_comb
    begin
        prod_x_next = tap * x_reg;
        prod_y_next = tap * y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            x_reg <= in_x;
            y_reg <= in_y;
        end
        if (advance)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
    end

    assign out_x  = x_reg;
    assign out_y  = y_reg;
    assign prod_x = prod_x_reg;
    assign prod_y = prod_y_reg;

endmodule

/* hdl/sgps_accum.sv */
// sgps_accum: two-level registered adder tree over the cell products
// then round to nearest and saturate to 32 bits for one coordinate
// depends on sgps_pkg
module sgps_accum #(
    parameter int N = 2 * sgps_pkg::HALF_WINDOW_DEFAULT + 1
) (
    input  logic             clk,
    input  logic             advance,
    input  sgps_pkg::prod_t  prod [N],
    output sgps_pkg::coord_t value,
    output logic             sat
);
    import sgps_pkg::*;

    localparam int NP    = (N + 1) / 2;
    localparam int ACC_W = PROD_W + $clog2(N);
    localparam int Q_W   = ACC_W - FRAC_W;

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [Q_W-1:0] Q_MAX =
        {{(Q_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN =
        {{(Q_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

    logic signed [ACC_W-1:0] pair_reg  [NP];
    logic signed [ACC_W-1:0] pair_next [NP];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] rnd;
    logic signed [Q_W-1:0]   q;
    logic                    sat_hi;
    logic                    sat_lo;

    for (genvar i = 0; i < NP; i++)
    begin : g_pair
        if (2 * i + 1 < N)
        begin : g_two
            assign pair_next[i] = ACC_W'(prod[2 * i]) + ACC_W'(prod[2 * i + 1]);
        end
        else
        begin : g_one
            assign pair_next[i] = ACC_W'(prod[2 * i]);
        end
    end

    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < NP; i++)
        begin
            acc_next = acc_next + pair_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pair_reg <= pair_next;
            acc_reg  <= acc_next;
        end
    end

    // floor of (sum + half) / 2^16
    always_comb
    begin
        rnd    = acc_reg + HALF_LSB;
        q      = rnd[ACC_W-1:FRAC_W];
        sat_hi = q > Q_MAX;
        sat_lo = q < Q_MIN;
        if (sat_hi)
        begin
            value = Q_MAX[COORD_W-1:0];
        end
        else if (sat_lo)
        begin
            value = Q_MIN[COORD_W-1:0];
        end
        else
        begin
            value = q[COORD_W-1:0];
        end
        sat = sat_hi | sat_lo;
    end

endmodule

/* hdl/savitzky_golay_path_smoother.sv */
// savitzky_golay_path_smoother: top level of the streaming path smoother
// holds tap registers, issue control, the cell chain, adder trees and output skid
// depends on sgps_pkg, sgps_cell, sgps_accum
//
// Takes one path point per beat and returns points that trail the input by
// HALF_WINDOW points: each accepted point from the (HALF_WINDOW+1)-th of a path
// on yields one result, filtered once the window is full and raw before that.
// The first and last HALF_WINDOW points of a path pass raw. One point is taken
// every cycle while the output skid stage is empty; after the end-of-path beat
// the input also stalls while the buffered points are flushed, after any trailing
// result of that beat, as the chain issues one result per cycle while the skid
// stage is empty. A result follows the point beat that causes it through the
// issue state, the cell products, two adder tree levels and the output register.
// Taps are to be written through the configuration port only while the block is
// idle; the block itself does not enforce this. Offsets beyond four weigh zero.
module savitzky_golay_path_smoother #(
    parameter int HALF_WINDOW = sgps_pkg::HALF_WINDOW_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sgps_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [sgps_pkg::TAP_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  sgps_pkg::coord_t                    pos_x,
    input  sgps_pkg::coord_t                    pos_y,
    input  logic                                last_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output sgps_pkg::coord_t                    out_x,
    output sgps_pkg::coord_t                    out_y,
    output logic                                was_smoothed,
    output logic                                saturated,
    output logic                                last_out
);
    import sgps_pkg::*;

    localparam int WIN    = 2 * HALF_WINDOW + 1;
    localparam int FILL_W = $clog2(WIN);
    localparam int IDX_W  = $clog2(WIN);
    localparam int CNT_W  = $clog2(HALF_WINDOW + 1);

    tap_t tap_reg [NUM_TAPS];

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              mid_pending_reg;
    logic              mid_pending_next;
    logic              mid_smooth_reg;
    logic              mid_smooth_next;
    logic [CNT_W-1:0]  flush_cnt_reg;
    logic [CNT_W-1:0]  flush_cnt_next;
    logic [FILL_W-1:0] flush_len;

    slot_t   issue;
    slot_t   p_slot_reg;
    slot_t   s1_slot_reg;
    slot_t   s2_slot_reg;
    result_t res;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;

    logic             in_beat;
    logic             out_beat;
    logic             advance;
    logic             push;
    logic [IDX_W-1:0] flush_idx;

    coord_t win_x    [WIN];
    coord_t win_y    [WIN];
    tap_t   cell_tap [WIN];
    prod_t  prod_x   [WIN];
    prod_t  prod_y   [WIN];
    coord_t acc_x;
    coord_t acc_y;
    logic   sat_x;
    logic   sat_y;

    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg || (flush_cnt_reg != '0);
    assign in_beat  = in_valid && !in_stall;
    assign out_beat = main_valid_reg && !out_stall;

    // tap registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg[REG_TAP_CENTER] <= TAP_CENTER_RST;
            tap_reg[REG_TAP_OFF1]   <= TAP_OFF1_RST;
            tap_reg[REG_TAP_OFF2]   <= TAP_OFF2_RST;
            tap_reg[REG_TAP_OFF3]   <= TAP_OFF3_RST;
            tap_reg[REG_TAP_OFF4]   <= TAP_OFF4_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TAP_CENTER: tap_reg[REG_TAP_CENTER] <= cfg_data;
                REG_TAP_OFF1:   tap_reg[REG_TAP_OFF1]   <= cfg_data;
                REG_TAP_OFF2:   tap_reg[REG_TAP_OFF2]   <= cfg_data;
                REG_TAP_OFF3:   tap_reg[REG_TAP_OFF3]   <= cfg_data;
                REG_TAP_OFF4:   tap_reg[REG_TAP_OFF4]   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // cell chain
    for (genvar k = 0; k < WIN; k++)
    begin : g_cell
        localparam int D = (k >= HALF_WINDOW) ? k - HALF_WINDOW : HALF_WINDOW - k;
        coord_t chain_x;
        coord_t chain_y;

        if (D < NUM_TAPS)
        begin : g_tap
            assign cell_tap[k] = tap_reg[D];
        end
        else
        begin : g_zero
            assign cell_tap[k] = '0;
        end

        if (k == 0)
        begin : g_head
            assign chain_x = pos_x;
            assign chain_y = pos_y;
        end
        else
        begin : g_link
            assign chain_x = win_x[k - 1];
            assign chain_y = win_y[k - 1];
        end

        sgps_cell u_cell (
            .clk      (clk),
            .shift_en (in_beat),
            .advance  (advance),
            .in_x     (chain_x),
            .in_y     (chain_y),
            .tap      (cell_tap[k]),
            .out_x    (win_x[k]),
            .out_y    (win_y[k]),
            .prod_x   (prod_x[k]),
            .prod_y   (prod_y[k])
        );
    end

    sgps_accum #(.N(WIN)) u_accum_x (
        .clk     (clk),
        .advance (advance),
        .prod    (prod_x),
        .value   (acc_x),
        .sat     (sat_x)
    );

    sgps_accum #(.N(WIN)) u_accum_y (
        .clk     (clk),
        .advance (advance),
        .prod    (prod_y),
        .value   (acc_y),
        .sat     (sat_y)
    );

    // issue: trailing result first, then flushed points oldest first
    assign flush_idx = IDX_W'(flush_cnt_reg - CNT_W'(1));

    always_comb
    begin
        issue = '0;
        if (mid_pending_reg)
        begin
            issue.valid  = 1'b1;
            issue.smooth = mid_smooth_reg;
            issue.raw_x  = win_x[HALF_WINDOW];
            issue.raw_y  = win_y[HALF_WINDOW];
        end
        else if (flush_cnt_reg != '0)
        begin
            issue.valid = 1'b1;
            issue.last  = (flush_cnt_reg == CNT_W'(1));
            issue.raw_x = win_x[flush_idx];
            issue.raw_y = win_y[flush_idx];
        end
    end

    always_comb
    begin
        fill_next        = fill_reg;
        mid_pending_next = mid_pending_reg;
        mid_smooth_next  = mid_smooth_reg;
        flush_cnt_next   = flush_cnt_reg;
        flush_len        = (fill_reg + FILL_W'(1) < FILL_W'(HALF_WINDOW)) ?
                           fill_reg + FILL_W'(1) : FILL_W'(HALF_WINDOW);
        if (advance)
        begin
            if (mid_pending_reg)
            begin
                mid_pending_next = 1'b0;
            end
            else if (flush_cnt_reg != '0)
            begin
                flush_cnt_next = flush_cnt_reg - CNT_W'(1);
            end
        end
        if (in_beat)
        begin
            mid_pending_next = fill_reg >= FILL_W'(HALF_WINDOW);
            mid_smooth_next  = fill_reg >= FILL_W'(2 * HALF_WINDOW);
            if (last_in)
            begin
                flush_cnt_next = CNT_W'(flush_len);
                fill_next      = '0;
            end
            else if (fill_reg + FILL_W'(1) < FILL_W'(2 * HALF_WINDOW))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            else
            begin
                fill_next = FILL_W'(2 * HALF_WINDOW);
            end
        end
    end

    // result from the last tree stage
    always_comb
    begin
        res.smoothed = s2_slot_reg.smooth;
        res.last     = s2_slot_reg.last;
        res.sat      = s2_slot_reg.smooth && (sat_x || sat_y);
        res.x        = s2_slot_reg.smooth ? acc_x : s2_slot_reg.raw_x;
        res.y        = s2_slot_reg.smooth ? acc_y : s2_slot_reg.raw_y;
    end

    // output register with skid stage
    assign push = advance && s2_slot_reg.valid;

    always_comb
    begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_beat)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || out_beat)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_beat)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            mid_pending_reg <= 1'b0;
            mid_smooth_reg  <= 1'b0;
            flush_cnt_reg   <= '0;
            p_slot_reg      <= '0;
            s1_slot_reg     <= '0;
            s2_slot_reg     <= '0;
            main_valid_reg  <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg        <= fill_next;
            mid_pending_reg <= mid_pending_next;
            mid_smooth_reg  <= mid_smooth_next;
            flush_cnt_reg   <= flush_cnt_next;
            main_valid_reg  <= main_valid_next;
            skid_valid_reg  <= skid_valid_next;
            if (advance)
            begin
                p_slot_reg  <= issue;
                s1_slot_reg <= p_slot_reg;
                s2_slot_reg <= s1_slot_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = main_valid_reg;
    assign out_x        = main_reg.x;
    assign out_y        = main_reg.y;
    assign was_smoothed = main_reg.smoothed;
    assign saturated    = main_reg.sat;
    assign last_out     = main_reg.last;

    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds a beat while output register is empty");

    a_last_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && last_in |=> flush_cnt_reg != '0)
        else $error("end of path did not start a flush");

    a_last_is_raw: assert property (@(posedge clk) disable iff (!rst_n)
        s2_slot_reg.valid && s2_slot_reg.last |-> !s2_slot_reg.smooth)
        else $error("final point of a path marked as filtered");

    a_sat_only_smoothed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !was_smoothed |-> !saturated)
        else $error("raw point flagged as saturated");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(2 * HALF_WINDOW))
        else $error("fill count beyond window");

endmodule

/* bench/sgps_checker.sv */
// sgps_checker: watches the config port and both point channels of the path smoother
// keeps its own tap set and raw point history, predicts each result and compares it
// depends on sgps_pkg
module sgps_checker #(
    parameter int HALF_WINDOW = sgps_pkg::HALF_WINDOW_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sgps_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [sgps_pkg::TAP_W-1:0]     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  sgps_pkg::coord_t               pos_x,
    input  sgps_pkg::coord_t               pos_y,
    input  logic                           last_in,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  sgps_pkg::coord_t               out_x,
    input  sgps_pkg::coord_t               out_y,
    input  logic                           was_smoothed,
    input  logic                           saturated,
    input  logic                           last_out,
    output int                             fail_count,
    output int                             pending,
    output int                             checked
);
    import sgps_pkg::*;

    localparam int DEPTH = 2 * HALF_WINDOW + 1;
    localparam longint COORD_MAX = 2147483647;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    tap_t    taps [NUM_TAPS];
    coord_t  hist_x [DEPTH];
    coord_t  hist_y [DEPTH];
    int      fill;
    result_t expected_q [$];

    // symmetric fir over the raw history, index 0 newest
    function automatic coord_t fir_point(input bit use_y, inout logic sat);
        longint acc;
        longint w;
        longint q;
        int     d;
        acc = 0;
        for (int k = 0; k < DEPTH; k++)
        begin
            d = (k >= HALF_WINDOW) ? k - HALF_WINDOW : HALF_WINDOW - k;
            w = (d < NUM_TAPS) ? longint'(taps[d]) : 0;
            acc += w * longint'(use_y ? hist_y[k] : hist_x[k]);
        end
        q = (acc + 32768) >>> FRAC_W;
        if (q > COORD_MAX)
        begin
            sat = 1'b1;
            q = COORD_MAX;
        end
        else if (q < COORD_MIN)
        begin
            sat = 1'b1;
            q = COORD_MIN;
        end
        return coord_t'(q);
    endfunction

    task automatic queue_result(input result_t r);
        expected_q = {expected_q, r};
    endtask

    task automatic take_point(input coord_t x, input coord_t y, input logic last);
        result_t r;
        int      j;
        int      cnt;
        logic    sat;
        j = fill;
        for (int k = DEPTH - 1; k > 0; k--)
        begin
            hist_x[k] = hist_x[k-1];
            hist_y[k] = hist_y[k-1];
        end
        hist_x[0] = x;
        hist_y[0] = y;
        if (j >= HALF_WINDOW)
        begin
            r.last = 1'b0;
            if (j >= 2 * HALF_WINDOW)
            begin
                sat = 1'b0;
                r.x = fir_point(1'b0, sat);
                r.y = fir_point(1'b1, sat);
                r.smoothed = 1'b1;
                r.sat = sat;
            end
            else
            begin
                r.x = hist_x[HALF_WINDOW];
                r.y = hist_y[HALF_WINDOW];
                r.smoothed = 1'b0;
                r.sat = 1'b0;
            end
            queue_result(r);
        end
        if (last)
        begin
            // flush the held points raw, oldest first
            cnt = (j + 1 < HALF_WINDOW) ? j + 1 : HALF_WINDOW;
            for (int k = cnt; k > 0; k--)
            begin
                r.x = hist_x[k-1];
                r.y = hist_y[k-1];
                r.smoothed = 1'b0;
                r.sat = 1'b0;
                r.last = (k == 1);
                queue_result(r);
            end
            fill = 0;
        end
        else
        begin
            fill = (j + 1 < 2 * HALF_WINDOW) ? j + 1 : 2 * HALF_WINDOW;
        end
    endtask

    task automatic check_field(input string label, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: result with nothing expected, x=%0d y=%0d", $time, out_x, out_y);
            fail_count++;
        end
        else
        begin
            want = expected_q.pop_front();
            check_field("out_x", $signed(want.x), out_x);
            check_field("out_y", $signed(want.y), out_y);
            check_field("was_smoothed", want.smoothed, was_smoothed);
            check_field("saturated", want.sat, saturated);
            check_field("last_out", want.last, last_out);
        end
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps[REG_TAP_CENTER] = TAP_CENTER_RST;
            taps[REG_TAP_OFF1]   = TAP_OFF1_RST;
            taps[REG_TAP_OFF2]   = TAP_OFF2_RST;
            taps[REG_TAP_OFF3]   = TAP_OFF3_RST;
            taps[REG_TAP_OFF4]   = TAP_OFF4_RST;
            fill = 0;
            expected_q.delete();
            pending = 0;
            fail_count = 0;
            checked = 0;
        end
        else
        begin
            // writes to indexes past the last tap are ignored
            if (cfg_we && cfg_index < NUM_TAPS)
            begin
                taps[cfg_index] = tap_t'(cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                take_point(pos_x, pos_y, last_in);
            end
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            pending = expected_q.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// tb_top: stimulus and verdict for the path smoother
// drives taps, point paths and output stalls; sgps_checker does all prediction
// depends on sgps_pkg, sgps_checker, savitzky_golay_path_smoother
module tb_top;
    import sgps_pkg::*;

    localparam int HW             = HALF_WINDOW_DEFAULT;
    localparam int NUM_SETTINGS   = 6;
    localparam int PHASE_POINTS   = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam coord_t COORD_HI   = 32'sh7fff_ffff;
    localparam coord_t COORD_LO   = 32'sh8000_0000;
    localparam tap_t   TAP_MAX    = {1'b0, {(TAP_W-1){1'b1}}};
    localparam tap_t   TAP_MIN    = {1'b1, {(TAP_W-1){1'b0}}};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [TAP_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    coord_t               pos_x;
    coord_t               pos_y;
    logic                 last_in;
    logic                 out_valid;
    logic                 out_stall;
    coord_t               out_x;
    coord_t               out_y;
    logic                 was_smoothed;
    logic                 saturated;
    logic                 last_out;

    int fail_count;
    int pending;
    int checked;
    int points_sent;
    int paths_sent;
    int stuck;
    bit quiet;

    savitzky_golay_path_smoother #(.HALF_WINDOW(HW)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .last_in(last_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .was_smoothed(was_smoothed),
        .saturated(saturated), .last_out(last_out)
    );

    sgps_checker #(.HALF_WINDOW(HW)) chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .last_in(last_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .was_smoothed(was_smoothed),
        .saturated(saturated), .last_out(last_out),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck = 0;
        end
        else
        begin
            stuck++;
            if (stuck >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, stuck);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // output side: random hold-off before each result beat
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_point(input coord_t x, input coord_t y, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        pos_x = x;
        pos_y = y;
        last_in = last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        points_sent++;
        if (last)
        begin
            paths_sent++;
        end
    endtask

    function automatic coord_t extreme_coord();
        case ($urandom_range(0, 4))
            0: return COORD_HI;
            1: return COORD_LO;
            2: return '0;
            3: return '1;
            default: return coord_t'($urandom());
        endcase
    endfunction

    task automatic send_path(input int len, input int style);
        coord_t x;
        coord_t y;
        x = coord_t'($urandom()) >>> 3;
        y = coord_t'($urandom()) >>> 3;
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0:
                begin
                    x = coord_t'($urandom());
                    y = coord_t'($urandom());
                end
                1:
                begin
                    // smooth trajectory with small steps
                    x += coord_t'($urandom()) >>> 13;
                    y += coord_t'($urandom()) >>> 13;
                end
                default:
                begin
                    x = extreme_coord();
                    y = extreme_coord();
                end
            endcase
            send_point(x, y, i == len - 1);
        end
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2 * HW + 6) @(negedge clk);
    endtask

    task automatic write_tap(input int idx, input tap_t value);
        cfg_we = 1'b1;
        cfg_index = REG_IDX_W'(idx);
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        tap_t setting;
        int   start;
        int   len;
        int   style;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        last_in = 1'b0;
        quiet = 1'b0;
        points_sent = 0;
        paths_sent = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset taps: short path, single point, half-window-plus-one, full window plus one
        send_point(COORD_HI, COORD_LO, 1'b0);
        send_point(COORD_LO, COORD_HI, 1'b0);
        send_point('0, '1, 1'b1);
        send_point('1, '0, 1'b1);
        quiet = 1'b1;
        send_path(HW + 1, 2);
        quiet = 1'b0;
        for (int i = 0; i < 2 * HW + 2; i++)
        begin
            send_point(i[0] ? COORD_LO : COORD_HI, i[0] ? COORD_HI : COORD_LO,
                       i == 2 * HW + 1);
        end

        for (int phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            wait_idle();
            write_tap(NUM_TAPS + $urandom_range(0, 2), tap_t'($urandom()));
            for (int r = 0; r < NUM_TAPS; r++)
            begin
                case (phase)
                    0: setting = tap_t'($urandom());
                    1: setting = TAP_MAX;
                    2: setting = TAP_MIN;
                    3: setting = (r == REG_TAP_CENTER) ? tap_t'(1 << FRAC_W) : '0;
                    4:
                    begin
                        case ($urandom_range(0, 2))
                            0: setting = TAP_MAX;
                            1: setting = TAP_MIN;
                            default: setting = tap_t'($urandom());
                        endcase
                    end
                    default:
                    begin
                        case (r)
                            REG_TAP_CENTER: setting = TAP_CENTER_RST;
                            REG_TAP_OFF1:   setting = TAP_OFF1_RST;
                            REG_TAP_OFF2:   setting = TAP_OFF2_RST;
                            REG_TAP_OFF3:   setting = TAP_OFF3_RST;
                            default:        setting = TAP_OFF4_RST;
                        endcase
                    end
                endcase
                write_tap(r, setting);
            end
            start = points_sent;
            while (points_sent - start < PHASE_POINTS)
            begin
                quiet = ($urandom_range(0, 4) == 0);
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * HW)
                                                  : $urandom_range(2 * HW + 1, 30);
                case ($urandom_range(0, 9))
                    0, 1, 2:    style = 0;
                    3, 4:       style = 2;
                    default:    style = 1;
                endcase
                send_path(len, style);
            end
            quiet = 1'b0;
        end

        wait_idle();
        $display("sent %0d points in %0d paths under %0d tap sets plus the reset taps",
                 points_sent, paths_sent, NUM_SETTINGS);
        $display("checked %0d result points against the predicted stream", checked);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/sgps_pkg.sv
hdl/sgps_cell.sv
hdl/sgps_accum.sv
hdl/savitzky_golay_path_smoother.sv
bench/sgps_checker.sv
bench/tb_top.sv
